// ----- rtl/ffha_pkg.sv -----
// ---------------------------------------------------------------------------
// ffha_pkg: shared types and codes for the first-fit heap allocator
// Command and status codes, request/result transfer types, register reset.
// ---------------------------------------------------------------------------
package ffha_pkg;

  // Command codes
  localparam logic [1:0] CMD_ALLOC      = 2'd0;
  localparam logic [1:0] CMD_PAGE_ALLOC = 2'd1;
  localparam logic [1:0] CMD_FREE       = 2'd2;

  // Status codes
  localparam logic [2:0] ST_DONE = 3'd0;
  localparam logic [2:0] ST_ZERO = 3'd1;
  localparam logic [2:0] ST_OOM  = 3'd2;
  localparam logic [2:0] ST_NULL = 3'd3;
  localparam logic [2:0] ST_BAD  = 3'd4;

  // Header length in words and smallest split-off payload in words
  localparam int HDR_WORDS       = 3;
  localparam int MIN_SPLIT_WORDS = 4;

  localparam logic [31:0] HEAP_BASE_RESET = 32'h0010_0000;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] request_size;
    logic [31:0] block_address;
  } req_t;

  typedef struct packed {
    logic [31:0] result_address;
    logic [2:0]  status;
  } rsp_t;

endpackage

// ----- rtl/first_fit_heap_allocator_core.sv -----
// ---------------------------------------------------------------------------
// first_fit_heap_allocator_core: first-fit allocator with split and merge
// Keeps the block headers of a fixed arena in one synchronous RAM.
// ---------------------------------------------------------------------------
// One command is taken when start is high and busy is low; its single result
// appears on result for one cycle with done high and cannot be held off.
// After reset the block writes the first header in S_INIT, then takes
// commands. Each block header visited takes a RAM read (S_RD) and a check
// (S_CHK), since the header RAM has one registered read port.
// Zero size, size wrap, null and malformed frees answer the cycle after
// start. Allocate walks the chain up to the first fit, plus S_SPLIT when the
// fit is split. Free walks the chain up to the freed block and adds S_NRD and
// S_NCHK to read the following header, if there is one, for merging.
// heap_base may be written at any idle time; addresses follow it at once.
module first_fit_heap_allocator_core
  import ffha_pkg::*;
#(
  parameter int HEAP_BYTES = 65536,
  parameter int PAGE_BYTES = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic        start,
  input  req_t        request,
  output logic        busy,
  output logic        done,
  output rsp_t        result
);

  localparam int ARENA_WORDS = HEAP_BYTES / 4;
  localparam int WW          = $clog2(ARENA_WORDS);
  localparam int CW          = WW + 1;
  localparam int PW          = $clog2(PAGE_BYTES);

  typedef struct packed {
    logic          free;
    logic [WW-1:0] size;
  } ent_t;

  typedef enum logic [2:0] {
    S_INIT, S_IDLE, S_RD, S_CHK, S_SPLIT, S_NRD, S_NCHK
  } state_t;

  state_t        state;
  logic [31:0]   heap_base;
  logic          is_free;
  logic [29:0]   need;
  logic [WW-1:0] cur, target, prev;
  logic          prev_free;
  logic [WW-1:0] prev_size, cur_size;
  logic [CW-1:0] nxt;

  // Header RAM
  ent_t          mem [ARENA_WORDS];
  ent_t          rd_data;
  logic          mem_we;
  logic [WW-1:0] mem_waddr, mem_raddr;
  ent_t          mem_wdata;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rd_data <= mem[mem_raddr];
  end

  assign busy = (state != S_IDLE);

  // Request decode
  logic [32:0] word_sum, page_sum, rounded;
  logic        zero_size, wrap;
  logic [31:0] off, off_hdr;
  logic [29:0] free_word;
  logic        free_bad;

  always_comb begin
    word_sum  = {1'b0, request.request_size} + 33'd3;
    page_sum  = {1'b0, request.request_size} + 33'(PAGE_BYTES - 1);
    rounded   = (request.command == CMD_PAGE_ALLOC)
              ? {page_sum[32:PW], PW'(0)} : {word_sum[32:2], 2'b00};
    zero_size = (request.request_size == 32'd0);
    wrap      = rounded[32];
    off       = request.block_address - heap_base;
    off_hdr   = off - 32'(HDR_WORDS * 4);
    free_word = off_hdr[31:2];
    free_bad  = (off < 32'(HDR_WORDS * 4)) || (off[1:0] != 2'b00)
             || (free_word >= 30'(ARENA_WORDS));
  end

  // Header check on read data
  logic [CW-1:0] cur_next, split_at;
  logic          fits, do_split;
  logic [WW-1:0] m_csize, m_sum;
  logic          m_nf;
  logic [CW-1:0] m_total, m_ext;

  always_comb begin
    cur_next = CW'(cur) + CW'(HDR_WORDS) + CW'(rd_data.size);
    fits     = rd_data.free && (30'(rd_data.size) >= need);
    do_split = 32'(rd_data.size) >= 32'(need) + 32'(HDR_WORDS + MIN_SPLIT_WORDS);
    split_at = CW'(cur) + CW'(HDR_WORDS) + CW'(need);
    // merge terms: in S_CHK there is no following block to read
    m_csize  = (state == S_CHK) ? rd_data.size : cur_size;
    m_nf     = (state == S_NCHK) && rd_data.free;
    m_ext    = m_nf ? CW'(HDR_WORDS) + CW'(rd_data.size) : '0;
    m_total  = prev_free
             ? CW'(prev_size) + CW'(HDR_WORDS) + CW'(m_csize) + m_ext
             : CW'(m_csize) + m_ext;
    m_sum    = m_total[WW-1:0];
  end

  logic [31:0] alloc_addr;
  assign alloc_addr = heap_base + 32'({CW'(cur) + CW'(HDR_WORDS), 2'b00});

  // RAM port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cur;
    mem_wdata = '0;
    mem_raddr = cur;
    unique case (state)
      S_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = '0;
        mem_wdata = '{free: 1'b1, size: WW'(ARENA_WORDS - HDR_WORDS)};
      end
      S_CHK: begin
        if (!is_free && fits) begin
          mem_we    = 1'b1;
          mem_wdata = '{free: 1'b0, size: do_split ? need[WW-1:0] : rd_data.size};
        end else if (is_free && cur == target && !rd_data.free
                     && cur_next >= CW'(ARENA_WORDS)) begin
          mem_we    = 1'b1;
          mem_waddr = prev_free ? prev : cur;
          mem_wdata = '{free: 1'b1, size: m_sum};
        end
      end
      S_SPLIT: begin
        mem_we    = 1'b1;
        mem_waddr = nxt[WW-1:0];
        mem_wdata = '{free: 1'b1,
                      size: WW'(cur_size - need[WW-1:0] - WW'(HDR_WORDS))};
      end
      S_NRD: mem_raddr = nxt[WW-1:0];
      S_NCHK: begin
        mem_we    = 1'b1;
        mem_waddr = prev_free ? prev : cur;
        mem_wdata = '{free: 1'b1, size: m_sum};
      end
      default: ;
    endcase
  end

  // Control sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      done      <= 1'b0;
      heap_base <= HEAP_BASE_RESET;
      prev_free <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_we) heap_base <= cfg_wdata;
      unique case (state)
        S_INIT: state <= S_IDLE;
        S_IDLE: begin
          if (start) begin
            cur                   <= '0;
            prev_free             <= 1'b0;
            result.result_address <= 32'd0;
            is_free               <= (request.command == CMD_FREE);
            need                  <= rounded[31:2];
            target                <= free_word[WW-1:0];
            case (request.command) inside
              CMD_ALLOC, CMD_PAGE_ALLOC: begin
                if (zero_size) begin
                  done          <= 1'b1;
                  result.status <= ST_ZERO;
                end else if (wrap) begin
                  done          <= 1'b1;
                  result.status <= ST_OOM;
                end else begin
                  result.status <= ST_DONE;
                  state         <= S_RD;
                end
              end
              CMD_FREE: begin
                if (request.block_address == 32'd0) begin
                  done          <= 1'b1;
                  result.status <= ST_NULL;
                end else if (free_bad) begin
                  done          <= 1'b1;
                  result.status <= ST_BAD;
                end else begin
                  result.status <= ST_DONE;
                  state         <= S_RD;
                end
              end
              default: begin
                done          <= 1'b1;
                result.status <= ST_DONE;
              end
            endcase
          end
        end
        S_RD: state <= S_CHK;
        S_CHK: begin
          if (!is_free) begin
            if (fits) begin
              cur_size <= rd_data.size;
              nxt      <= split_at;
              result   <= '{result_address: alloc_addr, status: ST_DONE};
              if (do_split) begin
                state <= S_SPLIT;
              end else begin
                done  <= 1'b1;
                state <= S_IDLE;
              end
            end else if (cur_next >= CW'(ARENA_WORDS)) begin
              result.status <= ST_OOM;
              done          <= 1'b1;
              state         <= S_IDLE;
            end else begin
              cur   <= cur_next[WW-1:0];
              state <= S_RD;
            end
          end else if (cur == target) begin
            cur_size <= rd_data.size;
            if (rd_data.free) begin
              result.status <= ST_BAD;
              done          <= 1'b1;
              state         <= S_IDLE;
            end else if (cur_next >= CW'(ARENA_WORDS)) begin
              done  <= 1'b1;
              state <= S_IDLE;
            end else begin
              nxt   <= cur_next;
              state <= S_NRD;
            end
          end else if (cur > target || cur_next >= CW'(ARENA_WORDS)) begin
            result.status <= ST_BAD;
            done          <= 1'b1;
            state         <= S_IDLE;
          end else begin
            prev      <= cur;
            prev_free <= rd_data.free;
            prev_size <= rd_data.size;
            cur       <= cur_next[WW-1:0];
            state     <= S_RD;
          end
        end
        S_SPLIT: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        S_NRD: state <= S_NCHK;
        S_NCHK: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  // A result is only ever presented as the sequencer returns to idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");

  // Every accepted command either answers at once or starts a walk
  a_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("command transfer lost");

  // Failures never return an address; frees leave it at zero too, though only failures are checked here
  a_fail_addr: assert property (@(posedge clk) disable iff (rst)
    (done && result.status != ST_DONE) |-> (result.result_address == 32'd0))
    else $error("address on failed command");
`endif

endmodule

// ----- tb/sv/tb_first_fit_heap_allocator_core.sv -----
// ---------------------------------------------------------------------------
// tb_first_fit_heap_allocator_core: self-checking bench for the heap allocator
// Drives allocate, page-allocate, free and unused commands with random gaps, keeps
// its own first-fit arena model and compares every result transfer with it.
// ---------------------------------------------------------------------------
module tb_first_fit_heap_allocator_core;
  import ffha_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int HEAP_BYTES  = 65536;
  localparam int PAGE_BYTES  = 4096;
  localparam int ARENA_WORDS = HEAP_BYTES / 4;
  localparam logic [1:0] CMD_NONE = 2'd3;
  localparam int CYCLE_LIMIT = 40000000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;
  logic        start = 1'b0;
  req_t        request = '0;
  logic        busy;
  logic        done;
  rsp_t        result;

  first_fit_heap_allocator_core #(
    .HEAP_BYTES(HEAP_BYTES),
    .PAGE_BYTES(PAGE_BYTES)
  ) dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .start(start), .request(request), .busy(busy), .done(done), .result(result)
  );

  always #2 clk = ~clk;

  // Arena model: header marks per word
  logic [31:0] arena_base;
  bit          blk_start [ARENA_WORDS];
  bit          blk_free  [ARENA_WORDS];
  int unsigned blk_words [ARENA_WORDS];
  logic [31:0] live_addrs [$];
  rsp_t        pending_results [$];
  int          error_count = 0;
  longint      cycle_count = 0;

  function automatic void arena_reset();
    for (int i = 0; i < ARENA_WORDS; i++) begin
      blk_start[i] = 0; blk_free[i] = 0; blk_words[i] = 0;
    end
    blk_start[0] = 1; blk_free[0] = 1;
    blk_words[0] = ARENA_WORDS - HDR_WORDS;
  endfunction

  function automatic void coalesce();
    int unsigned cur, nxt;
    cur = 0;
    while (cur < ARENA_WORDS) begin
      nxt = cur + HDR_WORDS + blk_words[cur];
      if (nxt >= ARENA_WORDS) break;
      if (blk_free[cur] && blk_free[nxt]) begin
        blk_words[cur] += HDR_WORDS + blk_words[nxt];
        blk_start[nxt] = 0; blk_free[nxt] = 0; blk_words[nxt] = 0;
      end else cur = nxt;
    end
  endfunction

  function automatic logic [2:0] carve(longint unsigned bytes, output logic [31:0] addr);
    longint unsigned rnd, need;
    int unsigned w, nw;
    addr = '0;
    if (bytes == 0) return ST_ZERO;
    rnd = (bytes + 3) & ~64'd3;
    if (rnd > 64'hFFFF_FFFF) return ST_OOM;
    need = rnd / 4;
    w = 0;
    while (w < ARENA_WORDS) begin
      if (blk_free[w] && blk_words[w] >= need) begin
        if (blk_words[w] >= need + HDR_WORDS + MIN_SPLIT_WORDS) begin
          nw = w + HDR_WORDS + int'(need);
          if (nw < ARENA_WORDS) begin
            blk_start[nw] = 1; blk_free[nw] = 1;
            blk_words[nw] = blk_words[w] - int'(need) - HDR_WORDS;
            blk_words[w] = int'(need);
          end
        end
        blk_free[w] = 0;
        addr = arena_base + (HDR_WORDS + w) * 4;
        return ST_DONE;
      end
      w = w + HDR_WORDS + blk_words[w];
    end
    return ST_OOM;
  endfunction

  function automatic logic [2:0] release_block(logic [31:0] addr);
    logic [31:0] off;
    int unsigned w;
    if (addr == 0) return ST_NULL;
    off = addr - arena_base;
    if (off < HDR_WORDS * 4 || off[1:0] != 0) return ST_BAD;
    if ((off - HDR_WORDS * 4) / 4 >= ARENA_WORDS) return ST_BAD;
    w = (off - HDR_WORDS * 4) / 4;
    if (!blk_start[w] || blk_free[w]) return ST_BAD;
    blk_free[w] = 1;
    coalesce();
    return ST_DONE;
  endfunction

  function automatic rsp_t allocator_outcome(req_t rq);
    rsp_t r;
    longint unsigned sz, pr;
    r = '0;
    sz = rq.request_size;
    case (rq.command)
      CMD_ALLOC: r.status = carve(sz, r.result_address);
      CMD_PAGE_ALLOC: begin
        pr = (sz + PAGE_BYTES - 1) / PAGE_BYTES * PAGE_BYTES;
        if (sz == 0) r.status = ST_ZERO;
        else if (pr > 64'hFFFF_FFFF) r.status = ST_OOM;
        else r.status = carve(pr, r.result_address);
      end
      CMD_FREE: r.status = release_block(rq.block_address);
      default: r.status = ST_DONE;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %h expected %h at cycle %0d", what, got, want, cycle_count);
    error_count++;
  endtask

  // Result checker: every done cycle is one transfer
  always @(posedge clk) begin
    rsp_t exp_r;
    cycle_count <= cycle_count + 1;
    if (!rst && done) begin
      if (pending_results.size() == 0)
        report_mismatch("unexpected result", result.result_address, 32'd0);
      else begin
        exp_r = pending_results.pop_front();
        if (result.result_address !== exp_r.result_address)
          report_mismatch("result_address", result.result_address, exp_r.result_address);
        if (result.status !== exp_r.status)
          report_mismatch("status", {29'd0, result.status}, {29'd0, exp_r.status});
      end
    end
  end

  always @(posedge clk) begin
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_first_fit_heap_allocator_core NOT OK");
      $finish;
    end
  end

  // start stays high between back-to-back commands; it drops only for a gap or a drain
  task automatic send_command(logic [1:0] cmd, logic [31:0] sz, logic [31:0] addr, bit gaps);
    req_t rq;
    rsp_t r;
    int gap;
    gap = gaps ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rq.command = cmd; rq.request_size = sz; rq.block_address = addr;
    start <= 1'b1;
    request <= rq;
    @(posedge clk);
    while (busy) @(posedge clk);
    r = allocator_outcome(rq);
    pending_results.push_back(r);
    if ((rq.command == CMD_ALLOC || rq.command == CMD_PAGE_ALLOC) && r.status == ST_DONE)
      live_addrs.push_back(r.result_address);
    if (rq.command == CMD_FREE && r.status == ST_DONE)
      foreach (live_addrs[i]) if (live_addrs[i] == addr) begin
        live_addrs.delete(i);
        break;
      end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_base(logic [31:0] b);
    drain();
    cfg_we <= 1'b1; cfg_wdata <= b;
    @(posedge clk);
    cfg_we <= 1'b0;
    arena_base = b;
  endtask

  function automatic logic [31:0] pick_live();
    if (live_addrs.size() == 0) return 32'd0;
    return live_addrs[$urandom_range(0, live_addrs.size() - 1)];
  endfunction

  task automatic test_directed();
    send_command(CMD_ALLOC, 0, 0, 0);
    send_command(CMD_PAGE_ALLOC, 0, 0, 0);
    send_command(CMD_ALLOC, 32'hFFFF_FFFF, 0, 0);
    send_command(CMD_ALLOC, 32'hFFFF_FFFD, 0, 0);
    send_command(CMD_PAGE_ALLOC, 32'hFFFF_F001, 0, 0);
    send_command(CMD_ALLOC, 1, 0, 0);
    send_command(CMD_ALLOC, 5, 0, 0);
    send_command(CMD_PAGE_ALLOC, 1, 0, 0);
    send_command(CMD_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
    send_command(CMD_FREE, 0, 0, 0);
    send_command(CMD_FREE, 0, arena_base + 13, 0);
    send_command(CMD_FREE, 0, arena_base + 4, 0);
    send_command(CMD_FREE, 0, arena_base + HEAP_BYTES + 12, 0);
    send_command(CMD_FREE, 0, arena_base + 16, 0);
    send_command(CMD_FREE, 0, arena_base + 12, 0);
    send_command(CMD_FREE, 0, arena_base + 12, 0);
    send_command(CMD_ALLOC, HEAP_BYTES, 0, 0);
    send_command(CMD_ALLOC, HEAP_BYTES - 12, 0, 0);
    send_command(CMD_ALLOC, 4, 0, 0);
    while (live_addrs.size() != 0) send_command(CMD_FREE, 0, pick_live(), 0);
  endtask

  task automatic test_random(int n);
    int k;
    logic [31:0] sz;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      case ($urandom_range(0, 3))
        0: sz = $urandom;
        1: sz = $urandom_range(1, 4096);
        default: sz = $urandom_range(1, 256);
      endcase
      if (k < 45) send_command(CMD_ALLOC, sz, $urandom, i % 7 != 0);
      else if (k < 55) send_command(CMD_PAGE_ALLOC, sz, $urandom, i % 7 != 0);
      else if (k < 88) send_command(CMD_FREE, $urandom, pick_live(), i % 7 != 0);
      else if (k < 95) send_command(CMD_FREE, $urandom, arena_base + ($urandom & 32'hFFFF),
                                    i % 7 != 0);
      else send_command(CMD_NONE, $urandom, $urandom, i % 7 != 0);
    end
  endtask

  // Base moves with blocks still allocated
  task automatic test_base_moves();
    send_command(CMD_ALLOC, 40, 0, 1);
    send_command(CMD_ALLOC, 100, 0, 1);
    write_base(32'hFFFF_F000);
    live_addrs.delete();
    send_command(CMD_FREE, 0, 32'hFFFF_F00C, 1);
    send_command(CMD_ALLOC, 8, 0, 1);
    test_random(200);
    write_base(32'h0000_0000);
    live_addrs.delete();
    send_command(CMD_FREE, 0, 32'd12, 1);
    test_random(200);
  endtask

  initial begin
    arena_base = HEAP_BASE_RESET;
    arena_reset();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(500);
    drain();
    test_random(300);
    write_base(32'h8000_0000);
    test_random(300);
    test_base_moves();
    write_base(HEAP_BASE_RESET);
    test_random(100);
    drain();
    if (error_count == 0) $display("tb_first_fit_heap_allocator_core OK");
    else $display("tb_first_fit_heap_allocator_core NOT OK");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/ffha_pkg.sv
rtl/first_fit_heap_allocator_core.sv
tb/sv/tb_first_fit_heap_allocator_core.sv
